/* src/kest_pkg.sv */
// Shared types and constants for the keyed event slot table.
package kest_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int ID_W           = 32;
	localparam int REF_W          = 32;
	localparam int OCC_W          = 5;
	localparam int ACTION_SHIFT   = 16;
	localparam logic [ACTION_SHIFT-1:0] ACTION_TAG = ACTION_SHIFT'(2);

	typedef enum logic [2:0] {
		REQ_POST        = 3'd0,
		REQ_POST_ACTION = 3'd1,
		REQ_CHECK       = 3'd2,
		REQ_TAKE        = 3'd3,
		REQ_CLEAR_FIRST = 3'd4,
		REQ_CLEAR_ALL   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FLUSH
	} fsm_t;

	// one slot as it travels along the ring
	typedef struct packed {
		logic [ID_W-1:0]  target;
		logic [REF_W-1:0] script;
	} slot_t;

endpackage

/* src/kest_cell.sv */
// One slot cell of the rotating ring.
module kest_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  kest_pkg::slot_t nxt,
	output kest_pkg::slot_t cur
);
	import kest_pkg::*;

	logic [ID_W-1:0]  target_q;
	logic [REF_W-1:0] script_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (shift) begin
			target_q <= nxt.target;
		end
	end

	// reference has no defined reset value
	always_ff @(posedge clk) begin
		if (shift) begin
			script_q <= nxt.script;
		end
	end

	assign cur.target = target_q;
	assign cur.script = script_q;

endmodule

/* src/keyed_event_slot_table.sv */
// Top level: ring of slot cells with a head-of-ring request engine.
//
// Sequence: an accepted request rotates the ring one full revolution in the
//   scan state, then its result is loaded into m_tdata once the output is free.
// Flow: a new request is taken only in the idle state; while scanning the ring
//   rotates one slot per cycle past the single compare unit at its head.
// Reset: arst_n clears every slot id (all empty), the FSM and the output
//   valid; stored references are left undefined.
module keyed_event_slot_table #(
	parameter int SLOT_COUNT = kest_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] target_id, [63:32] script_value
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [0] hit, [32:1] script_ref, [34:33] status,
	                               // [39:35] occupancy
);
	import kest_pkg::*;

	localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW   = $clog2(SLOT_COUNT + 1);
	localparam int OW   = (CW > OCC_W) ? CW : OCC_W;
	localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

	// ring: cell 0 is the head the engine looks at each cycle
	slot_t ring [SLOT_COUNT];
	slot_t head_new;
	logic  shift;

	genvar gi;
	generate
		for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
			slot_t feed;
			if (gi == SLOT_COUNT - 1) begin : g_tail
				assign feed = head_new;
			end else begin : g_mid
				assign feed = ring[gi+1];
			end
			kest_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (shift),
				.nxt   (feed),
				.cur   (ring[gi])
			);
		end
	endgenerate

	// request registers
	fsm_t             state_q, state_d;
	req_t             req_q;
	logic [ID_W-1:0]  id_q;
	logic [REF_W-1:0] ref_q;
	logic [SW-1:0]    step_q;
	logic             done_q;      // first-match (or post slot) already found
	logic [REF_W-1:0] taken_q;
	logic [OW-1:0]    occ_q;
	logic             m_tvalid_q;
	logic [39:0]      m_tdata_q;

	logic accept, out_free, load_out, last_step;
	logic head_match, head_empty, set_done, take_now;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_step = (step_q == LAST);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:  if (s_tvalid) state_d = FSM_SCAN;
			FSM_SCAN:  if (last_step) state_d = FSM_FLUSH;
			FSM_FLUSH: if (out_free) state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		s_tready = 1'b0;
		shift    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			FSM_IDLE:  s_tready = 1'b1;
			FSM_SCAN:  shift    = 1'b1;
			FSM_FLUSH: load_out = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// head-of-ring engine: decide what the current slot becomes
	assign head_match = (ring[0].target == id_q);
	assign head_empty = (ring[0].target == '0);

	always_comb begin
		head_new = ring[0];
		set_done = 1'b0;
		take_now = 1'b0;
		case (req_q)
			REQ_POST, REQ_POST_ACTION: begin
				if (!done_q && (head_match || head_empty)) begin
					head_new.target = id_q;
					head_new.script = ref_q;
					set_done        = 1'b1;
				end
			end
			REQ_CHECK: begin
				if (head_match) set_done = 1'b1;
			end
			REQ_TAKE: begin
				if (!done_q && head_match) begin
					head_new.target = '0;
					set_done        = 1'b1;
					take_now        = 1'b1;
				end
			end
			REQ_CLEAR_FIRST: begin
				if (!done_q && head_match) begin
					head_new.target = '0;
					set_done        = 1'b1;
				end
			end
			REQ_CLEAR_ALL: begin
				if (head_match) head_new.target = '0;
			end
			default: ;
		endcase
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
			occ_q  <= '0;
		end else if (accept) begin
			step_q <= '0;
			done_q <= 1'b0;
			occ_q  <= '0;
		end else if (shift) begin
			step_q <= last_step ? '0 : step_q + SW'(1);
			if (set_done) done_q <= 1'b1;
			if (head_new.target != '0) occ_q <= occ_q + OW'(1);
		end
	end

	// request payload; player action stores (value << 16) | 2
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(s_tuser);
			id_q    <= s_tdata[31:0];
			taken_q <= '0;
			if (req_t'(s_tuser) == REQ_POST_ACTION) begin
				ref_q <= {s_tdata[32 +: REF_W-ACTION_SHIFT], ACTION_TAG};
			end else begin
				ref_q <= s_tdata[63:32];
			end
		end else if (shift && take_now) begin
			taken_q <= ring[0].script;
		end
	end

	// result assembly
	logic          res_hit;
	status_t       res_status;
	logic [OCC_W-1:0] res_occ;

	always_comb begin
		res_hit    = done_q && (req_q == REQ_CHECK || req_q == REQ_TAKE);
		res_status = ST_OK;
		if ((req_q == REQ_POST || req_q == REQ_POST_ACTION) && !done_q) res_status = ST_FULL;
		if (req_q == REQ_TAKE && !done_q) res_status = ST_MISSING;
		res_occ = (occ_q > OW'(31)) ? OCC_W'(31) : occ_q[OCC_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {res_occ, res_status, taken_q, res_hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a new request always starts the ring at slot 0
	a_start_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (step_q == '0))
		else $error("request accepted with ring not at slot 0");

	// a full revolution ends in the flush state
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN && last_step) |=> (state_q == FSM_FLUSH))
		else $error("scan did not end after one revolution");

	// a hit never carries an error status
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[34:33] == ST_OK))
		else $error("hit reported with error status");

	// occupancy can not exceed the table size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_FLUSH) |-> (occ_q <= OW'(SLOT_COUNT)))
		else $error("occupancy count overran table size");

endmodule

/* bench/keyed_event_slot_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the keyed event slot table: mirror scoreboard, stream drivers, monitor.
module keyed_event_slot_table_tb;
	import kest_pkg::*;

	localparam int SLOTS           = SLOT_COUNT_DEF;
	localparam int RANDOM_REQUESTS = 1920;
	localparam int QUIET_TAIL      = 150;
	localparam int PHASE_LEN       = 80;
	localparam int ID_POOL         = 24;
	localparam int DRAIN_CYCLES    = 4 * (SLOTS + 2);
	localparam int CYCLE_LIMIT     = 400000;

	// request codes the block treats as no-ops
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef struct packed {
		logic             hit;
		logic [REF_W-1:0] script_ref;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} reply_t;

	// Mirror of the slot table. Each accepted request updates the mirror and
	// queues the reply it must produce; replies are matched in order.
	class slot_table_mirror;
		logic [ID_W-1:0]  slot_id [SLOTS];
		logic [REF_W-1:0] slot_ref [SLOTS];
		bit               ref_loaded [SLOTS];
		reply_t           awaiting [$];
		int               requests, replies, errors;
		int               hits, full_posts, missed_takes;

		function new();
			foreach (slot_id[i]) begin
				slot_id[i]    = '0;
				slot_ref[i]   = '0;
				ref_loaded[i] = 1'b0;
			end
			requests     = 0;
			replies      = 0;
			errors       = 0;
			hits         = 0;
			full_posts   = 0;
			missed_takes = 0;
		endfunction

		function int find_slot(input logic [ID_W-1:0] id);
			for (int i = 0; i < SLOTS; i++)
				if (slot_id[i] == id)
					return i;
			return SLOTS;
		endfunction

		// first slot that matches or is empty gets the entry
		function bit store(input logic [ID_W-1:0] id, input logic [REF_W-1:0] ref_val);
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_id[i] == id || slot_id[i] == '0) begin
					slot_id[i]    = id;
					slot_ref[i]   = ref_val;
					ref_loaded[i] = 1'b1;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// a take of id zero reads the first empty slot; it must have been written
		function bit zero_take_safe();
			int k;
			k = find_slot('0);
			return (k == SLOTS) || ref_loaded[k];
		endfunction

		function void note_request(input logic [2:0] req, input logic [ID_W-1:0] id,
		                           input logic [REF_W-1:0] val);
			reply_t r;
			int     k;
			int     occ;
			r.hit        = 1'b0;
			r.script_ref = '0;
			r.status     = ST_OK;
			case (req)
				REQ_POST: begin
					if (!store(id, val))
						r.status = ST_FULL;
				end
				REQ_POST_ACTION: begin
					if (!store(id, (val << ACTION_SHIFT) | REF_W'(ACTION_TAG)))
						r.status = ST_FULL;
				end
				REQ_CHECK: begin
					r.hit = (find_slot(id) < SLOTS);
				end
				REQ_TAKE: begin
					k = find_slot(id);
					if (k < SLOTS) begin
						r.hit        = 1'b1;
						r.script_ref = slot_ref[k];
						slot_id[k]   = '0;
					end else begin
						r.status = ST_MISSING;
					end
				end
				REQ_CLEAR_FIRST: begin
					k = find_slot(id);
					if (k < SLOTS)
						slot_id[k] = '0;
				end
				REQ_CLEAR_ALL: begin
					foreach (slot_id[i])
						if (slot_id[i] == id)
							slot_id[i] = '0;
				end
				default: begin
				end
			endcase
			occ = 0;
			foreach (slot_id[i])
				if (slot_id[i] != '0)
					occ++;
			r.occupancy = OCC_W'((occ > 31) ? 31 : occ);
			requests++;
			if (r.hit)
				hits++;
			if (r.status == ST_FULL)
				full_posts++;
			if (r.status == ST_MISSING)
				missed_takes++;
			awaiting.push_back(r);
		endfunction

		function void report(input string field, input logic [REF_W-1:0] want,
		                     input logic [REF_W-1:0] got);
			errors++;
			$display("%0t ERROR: %s expected %h actual %h", $time, field, want, got);
		endfunction

		function void check_reply(input logic [39:0] word);
			reply_t want;
			replies++;
			if (awaiting.size() == 0) begin
				errors++;
				$display("%0t ERROR: reply %h arrived with none outstanding", $time, word);
				return;
			end
			want = awaiting.pop_front();
			if (word[0] !== want.hit)
				report("hit", REF_W'(want.hit), REF_W'(word[0]));
			if (word[32:1] !== want.script_ref)
				report("script_ref", want.script_ref, word[32:1]);
			if (word[34:33] !== want.status)
				report("status", REF_W'(want.status), REF_W'(word[34:33]));
			if (word[39:35] !== want.occupancy)
				report("occupancy", REF_W'(want.occupancy), REF_W'(word[39:35]));
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	slot_table_mirror ledger = new();
	logic [ID_W-1:0]  id_pool [ID_POOL];
	bit               quiet = 1'b0;
	int               cycle_count = 0;

	keyed_event_slot_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	// Present one request and hold it until the block takes it. Called right
	// after a rising edge; returns on the accepting edge with valid still high.
	task automatic send_request(input logic [2:0] req, input logic [ID_W-1:0] id,
	                            input logic [REF_W-1:0] val);
		// never take id zero from a slot whose reference was never loaded
		if (req == REQ_TAKE && id == '0 && !ledger.zero_take_safe())
			id = '1;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {val, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ledger.note_request(req, id, val);
	endtask

	task automatic sender_pause(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Mostly ids from a small pool so posts collide and takes hit; some fully
	// random ids and some zeros.
	function automatic logic [ID_W-1:0] pick_id();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return $urandom();
		if (roll < 12)
			return '0;
		return id_pool[$urandom_range(0, ID_POOL - 1)];
	endfunction

	// Filling phases lean on posts to reach a full table, draining phases on
	// takes and clears.
	function automatic logic [2:0] pick_req(input bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (filling) begin
			if (roll < 45) return REQ_POST;
			if (roll < 60) return REQ_POST_ACTION;
			if (roll < 70) return REQ_CHECK;
			if (roll < 82) return REQ_TAKE;
			if (roll < 90) return REQ_CLEAR_FIRST;
			if (roll < 96) return REQ_CLEAR_ALL;
		end else begin
			if (roll < 15) return REQ_POST;
			if (roll < 20) return REQ_POST_ACTION;
			if (roll < 35) return REQ_CHECK;
			if (roll < 70) return REQ_TAKE;
			if (roll < 85) return REQ_CLEAR_FIRST;
			if (roll < 95) return REQ_CLEAR_ALL;
		end
		return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
	endfunction

	// result side: random ready runs and stall bursts
	initial begin
		int run_left;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				m_tready <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else if ($urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				run_left = $urandom_range(0, 24);
			end else begin
				m_tready <= 1'b0;
				run_left = $urandom_range(0, 8);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_reply(m_tdata);
	end

	initial begin
		int gap_pct;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = $urandom() | 32'h1;
		gap_pct = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses on an empty table, id zero, extremes, spare codes
		send_request(REQ_CHECK, 32'h5, '0);
		send_request(REQ_TAKE, 32'h5, '1);
		send_request(REQ_POST, '0, 32'hA5A5_5A5A);   // reference lands, slot stays empty
		send_request(REQ_TAKE, '0, '0);
		send_request(REQ_CHECK, '0, '0);
		send_request(REQ_POST, '1, '1);
		send_request(REQ_POST_ACTION, 32'h1, '1);
		send_request(REQ_SPARE_LO, '1, '1);
		send_request(REQ_SPARE_HI, '0, '0);
		// fill the rest of the table; the last post is refused
		for (int i = 2; i <= SLOTS; i++)
			send_request(REQ_POST, 32'h100 + i, $urandom());
		send_request(REQ_TAKE, '1, '0);
		send_request(REQ_POST_ACTION, 32'h1, '0);   // duplicate ahead of the older id 1
		send_request(REQ_CLEAR_FIRST, 32'h102, '0);
		send_request(REQ_CLEAR_ALL, 32'h1, '0);

		// random traffic in alternating fill and drain phases
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 25;
					default: gap_pct = 60;
				endcase
			end
			if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
				gap_pct = 0;
				quiet   = 1'b1;
			end
			if ($urandom_range(0, 99) < gap_pct)
				sender_pause($urandom_range(1, 9));
			send_request(pick_req((n / PHASE_LEN) % 2 == 0), pick_id(), $urandom());
		end
		s_tvalid <= 1'b0;

		while (ledger.awaiting.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests over all eight request codes, %0d replies checked.",
		         ledger.requests, ledger.replies);
		$display("Hits: %0d, posts refused on a full table: %0d, takes that missed: %0d",
		         ledger.hits, ledger.full_posts, ledger.missed_takes);
		if (ledger.errors == 0 && ledger.awaiting.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* keyed_event_slot_table.f */
src/kest_pkg.sv
src/kest_cell.sv
src/keyed_event_slot_table.sv
bench/keyed_event_slot_table_tb.sv
